FILE: hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check themselves (here the cursor engine).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/tcce_pkg.sv
// Constants and codes of the text console cursor engine.
package tcce_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int UNIT_W = 8;
  localparam int CNT_W  = 8;
  localparam int CODE_W = 8;
  localparam int CLR_W  = 8;
  localparam int FUNC_W = 2;
  localparam int IDX_W  = 2;

  localparam logic [UNIT_W-1:0] COLUMNS_U = UNIT_W'(COLUMNS);
  localparam logic [UNIT_W-1:0] ROWS_U    = UNIT_W'(ROWS);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);

  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;

  localparam logic [FUNC_W-1:0] FUNC_PUT  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_BACK = 2'd2;

  localparam logic [IDX_W-1:0] CFG_TEXT_COLOR = 2'd0;
  localparam logic [IDX_W-1:0] CFG_BACK_COLOR = 2'd1;

  localparam logic [CLR_W-1:0] TEXT_COLOR_RST = 8'd15;
  localparam logic [CLR_W-1:0] BACK_COLOR_RST = 8'd0;

  localparam logic [UNIT_W-1:0] UNIT_ZERO    = '0;
  localparam logic [UNIT_W-1:0] UNIT_INC     = UNIT_W'(1);
  localparam logic [UNIT_W-1:0] UNIT_DEC     = '1;
  localparam logic [UNIT_W-1:0] UNIT_NO_LIM  = '1;

endpackage

FILE: hw/rtl/tcce_if.sv
// Request, result and config channels of the text console cursor engine.
interface tcce_in_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::FUNC_W-1:0]      func;
  logic [tcce_pkg::CODE_W-1:0]      char_code;
  logic signed [tcce_pkg::UNIT_W-1:0] target_col;
  logic signed [tcce_pkg::UNIT_W-1:0] target_row;
  logic [tcce_pkg::CNT_W-1:0]       back_count;

  modport source (output valid, func, char_code, target_col, target_row, back_count,
                  input ready);
  modport sink   (input valid, func, char_code, target_col, target_row, back_count,
                  output ready);
endinterface

interface tcce_out_if;
  logic                        valid;
  logic                        ready;
  logic                        draw_glyph;
  logic [tcce_pkg::CODE_W-1:0] glyph_code;
  logic [tcce_pkg::COL_W-1:0]  glyph_col;
  logic [tcce_pkg::ROW_W-1:0]  glyph_row;
  logic [tcce_pkg::CLR_W-1:0]  glyph_fg;
  logic [tcce_pkg::CLR_W-1:0]  glyph_bg;
  logic                        scroll_request;
  logic [tcce_pkg::COL_W-1:0]  cursor_col;
  logic [tcce_pkg::ROW_W-1:0]  cursor_row;

  modport source (output valid, draw_glyph, glyph_code, glyph_col, glyph_row, glyph_fg,
                         glyph_bg, scroll_request, cursor_col, cursor_row,
                  input ready);
  modport sink   (input valid, draw_glyph, glyph_code, glyph_col, glyph_row, glyph_fg,
                        glyph_bg, scroll_request, cursor_col, cursor_row,
                  output ready);
endinterface

interface tcce_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcce_pkg::IDX_W-1:0]  reg_index;
  logic [tcce_pkg::CLR_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

FILE: hw/rtl/text_console_cursor_engine.sv
// Top level of the text console cursor engine: sequencer, shared step unit, result register.
//
//   channel  dir  handshake          carries
//   in_ch    in   valid/ready        func, char_code, target_col/row, back_count
//   out_ch   out  valid/ready        glyph draw request, scroll request, cursor
//   cfg_ch   in   valid/ready (=1)   reg_index, wdata (text and back colors)
//
// Sequencer path from request to result register: backspace, tab and the unused selector
// go straight to DONE; a plain draw steps the column (COL_INC), a newline the row (ROW_INC),
// a wrapping draw both; a set cursor checks the column (CHK_COL), then if in range the row
// (CHK_ROW); a move back steps the column (BK_COL) once per count and the row (BK_ROW) on
// each wrap to the row above, since the one adder/compare unit handles the column and then,
// on a wrap, the row. The next request is taken once the result is loaded. Reset sets the
// cursor and colors to their reset values and clears the control state. A stalled result
// holds in the output register; a finished command waits in its last state until that register frees up.
`include "assert_macros.svh"

module text_console_cursor_engine (
  input  logic         clk,
  input  logic         rst_n,
  tcce_in_if.sink      in_ch,
  tcce_out_if.source   out_ch,
  tcce_cfg_if.sink     cfg_ch
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_COL_INC = 3'd1;
  localparam logic [2:0] S_ROW_INC = 3'd2;
  localparam logic [2:0] S_CHK_COL = 3'd3;
  localparam logic [2:0] S_CHK_ROW = 3'd4;
  localparam logic [2:0] S_BK_COL  = 3'd5;
  localparam logic [2:0] S_BK_ROW  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_r, state_nxt;

  // Cursor and colors
  logic [tcce_pkg::COL_W-1:0] col_r, col_nxt;
  logic [tcce_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [tcce_pkg::CLR_W-1:0] text_color_r;
  logic [tcce_pkg::CLR_W-1:0] back_color_r;

  // Command held while it is worked on
  logic [tcce_pkg::UNIT_W-1:0] tcol_r, tcol_nxt;
  logic [tcce_pkg::UNIT_W-1:0] trow_r, trow_nxt;
  logic [tcce_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        draw_r, draw_nxt;
  logic                        scroll_r, scroll_nxt;
  logic [tcce_pkg::CODE_W-1:0] gcode_r, gcode_nxt;
  logic [tcce_pkg::COL_W-1:0]  gcol_r, gcol_nxt;
  logic [tcce_pkg::ROW_W-1:0]  grow_r, grow_nxt;
  logic [tcce_pkg::CLR_W-1:0]  gfg_r, gfg_nxt;
  logic [tcce_pkg::CLR_W-1:0]  gbg_r, gbg_nxt;

  // Result register
  logic                        ovalid_r;
  logic                        odraw_r;
  logic [tcce_pkg::CODE_W-1:0] ocode_r;
  logic [tcce_pkg::COL_W-1:0]  ogcol_r;
  logic [tcce_pkg::ROW_W-1:0]  ogrow_r;
  logic [tcce_pkg::CLR_W-1:0]  ofg_r;
  logic [tcce_pkg::CLR_W-1:0]  obg_r;
  logic                        oscroll_r;
  logic [tcce_pkg::COL_W-1:0]  ocol_r;
  logic [tcce_pkg::ROW_W-1:0]  orow_r;

  // Shared step unit: one add, one compare against a limit, one zero test
  logic [tcce_pkg::UNIT_W-1:0] unit_a, unit_add, unit_lim, unit_res;
  logic                        unit_ge, unit_zero;

  logic in_acc, out_load;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == S_DONE) && (!ovalid_r || out_ch.ready);
  assign cfg_ch.ready = 1'b1;

  // Select the unit's operands for the current step.
  always_comb begin
    unit_a   = tcce_pkg::UNIT_ZERO;
    unit_add = tcce_pkg::UNIT_ZERO;
    unit_lim = tcce_pkg::UNIT_NO_LIM;
    unique case (state_r)
      S_COL_INC: begin
        unit_a   = tcce_pkg::UNIT_W'(col_r);
        unit_add = tcce_pkg::UNIT_INC;
        unit_lim = tcce_pkg::COLUMNS_U;
      end
      S_ROW_INC: begin
        unit_a   = tcce_pkg::UNIT_W'(row_r);
        unit_add = tcce_pkg::UNIT_INC;
        unit_lim = tcce_pkg::ROWS_U;
      end
      S_CHK_COL: begin
        unit_a   = tcol_r;
        unit_lim = tcce_pkg::COLUMNS_U;
      end
      S_CHK_ROW: begin
        unit_a   = trow_r;
        unit_lim = tcce_pkg::ROWS_U;
      end
      S_BK_COL: begin
        unit_a   = tcce_pkg::UNIT_W'(col_r);
        unit_add = tcce_pkg::UNIT_DEC;
      end
      S_BK_ROW: begin
        unit_a   = tcce_pkg::UNIT_W'(row_r);
        unit_add = tcce_pkg::UNIT_DEC;
      end
      default: begin
      end
    endcase
  end

  // Negative targets read as 128 or more, so they fail the limit compare too.
  assign unit_res  = unit_a + unit_add;
  assign unit_ge   = (unit_res >= unit_lim);
  assign unit_zero = (unit_a == tcce_pkg::UNIT_ZERO);

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    tcol_nxt   = tcol_r;
    trow_nxt   = trow_r;
    cnt_nxt    = cnt_r;
    draw_nxt   = draw_r;
    scroll_nxt = scroll_r;
    gcode_nxt  = gcode_r;
    gcol_nxt   = gcol_r;
    grow_nxt   = grow_r;
    gfg_nxt    = gfg_r;
    gbg_nxt    = gbg_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Start every command with an empty glyph and no scroll.
          draw_nxt   = 1'b0;
          scroll_nxt = 1'b0;
          gcode_nxt  = '0;
          gcol_nxt   = '0;
          grow_nxt   = '0;
          gfg_nxt    = '0;
          gbg_nxt    = '0;
          tcol_nxt   = in_ch.target_col;
          trow_nxt   = in_ch.target_row;
          cnt_nxt    = in_ch.back_count;
          state_nxt  = S_DONE;
          unique case (in_ch.func)
            tcce_pkg::FUNC_PUT: begin
              case (in_ch.char_code) inside
                tcce_pkg::CODE_NEWLINE: begin
                  col_nxt   = '0;
                  state_nxt = S_ROW_INC;
                end
                tcce_pkg::CODE_BACKSPACE, tcce_pkg::CODE_TAB: begin
                  state_nxt = S_DONE;
                end
                default: begin
                  draw_nxt  = 1'b1;
                  gcode_nxt = in_ch.char_code;
                  gcol_nxt  = col_r;
                  grow_nxt  = row_r;
                  gfg_nxt   = text_color_r;
                  gbg_nxt   = back_color_r;
                  state_nxt = S_COL_INC;
                end
              endcase
            end
            tcce_pkg::FUNC_SET:  state_nxt = S_CHK_COL;
            tcce_pkg::FUNC_BACK: begin
              if (in_ch.back_count != '0) begin
                state_nxt = S_BK_COL;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_COL_INC: begin
        // Wrap to the next row at the right edge.
        if (unit_ge) begin
          col_nxt   = '0;
          state_nxt = S_ROW_INC;
        end else begin
          col_nxt   = unit_res[tcce_pkg::COL_W-1:0];
          state_nxt = S_DONE;
        end
      end
      S_ROW_INC: begin
        // Past the last row: hold on it and ask for a scroll.
        if (unit_ge) begin
          row_nxt    = tcce_pkg::ROW_LAST;
          scroll_nxt = 1'b1;
        end else begin
          row_nxt = unit_res[tcce_pkg::ROW_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_CHK_COL: begin
        state_nxt = unit_ge ? S_DONE : S_CHK_ROW;
      end
      S_CHK_ROW: begin
        if (!unit_ge) begin
          col_nxt = tcol_r[tcce_pkg::COL_W-1:0];
          row_nxt = trow_r[tcce_pkg::ROW_W-1:0];
        end
        state_nxt = S_DONE;
      end
      S_BK_COL: begin
        cnt_nxt = cnt_r - tcce_pkg::CNT_W'(1);
        if (unit_zero) begin
          col_nxt   = tcce_pkg::COL_LAST;
          state_nxt = S_BK_ROW;
        end else begin
          col_nxt   = unit_res[tcce_pkg::COL_W-1:0];
          state_nxt = (cnt_r == tcce_pkg::CNT_W'(1)) ? S_DONE : S_BK_COL;
        end
      end
      S_BK_ROW: begin
        // Row 0 stays on row 0.
        if (!unit_zero) begin
          row_nxt = unit_res[tcce_pkg::ROW_W-1:0];
        end
        state_nxt = (cnt_r == '0) ? S_DONE : S_BK_COL;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      col_r   <= '0;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
    end
  end

  // Command payload needs no reset.
  always_ff @(posedge clk) begin
    tcol_r   <= tcol_nxt;
    trow_r   <= trow_nxt;
    cnt_r    <= cnt_nxt;
    draw_r   <= draw_nxt;
    scroll_r <= scroll_nxt;
    gcode_r  <= gcode_nxt;
    gcol_r   <= gcol_nxt;
    grow_r   <= grow_nxt;
    gfg_r    <= gfg_nxt;
    gbg_r    <= gbg_nxt;
  end

  // Color registers; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcce_pkg::TEXT_COLOR_RST;
      back_color_r <= tcce_pkg::BACK_COLOR_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_index)
        tcce_pkg::CFG_TEXT_COLOR: text_color_r <= cfg_ch.wdata;
        tcce_pkg::CFG_BACK_COLOR: back_color_r <= cfg_ch.wdata;
        default: begin
        end
      endcase
    end
  end

  // Result register: load when free or being taken, clear when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (out_load) begin
      ovalid_r <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      odraw_r   <= draw_r;
      ocode_r   <= gcode_r;
      ogcol_r   <= gcol_r;
      ogrow_r   <= grow_r;
      ofg_r     <= gfg_r;
      obg_r     <= gbg_r;
      oscroll_r <= scroll_r;
      ocol_r    <= col_r;
      orow_r    <= row_r;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.draw_glyph     = odraw_r;
  assign out_ch.glyph_code     = ocode_r;
  assign out_ch.glyph_col      = ogcol_r;
  assign out_ch.glyph_row      = ogrow_r;
  assign out_ch.glyph_fg       = ofg_r;
  assign out_ch.glyph_bg       = obg_r;
  assign out_ch.scroll_request = oscroll_r;
  assign out_ch.cursor_col     = ocol_r;
  assign out_ch.cursor_row     = orow_r;

  // Checks
  `ASSERT_CLK(a_busy_after_req, in_acc |=> !in_ch.ready,
              "engine took a request while busy")
  `ASSERT_CLK(a_cursor_in_grid,
              (col_r <= tcce_pkg::COL_LAST) && (row_r <= tcce_pkg::ROW_LAST),
              "cursor left the grid")
  `ASSERT_CLK(a_no_draw_zero,
              (ovalid_r && !odraw_r) |-> (ocode_r == '0 && ofg_r == '0 && obg_r == '0 &&
                                          ogcol_r == '0 && ogrow_r == '0),
              "glyph fields set without a draw")
  `ASSERT_CLK(a_scroll_pos,
              (ovalid_r && oscroll_r) |-> (orow_r == tcce_pkg::ROW_LAST && ocol_r == '0),
              "scroll with cursor off the last row start")

endmodule
